>>> src/mmas_pkg.sv
// ============================================================================
// mmas_pkg - moving average sampler shared definitions
// Sizes, field widths and stream packing used by the sampler and its checker.
// ============================================================================
package mmas_pkg;

    // block sizing
    localparam int CHANNELS    = 5;
    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 12;

    // fixed field widths of the stream payload
    localparam int SAMPLE_FIELD_W = 12;
    localparam int CHAN_FIELD_W   = 3;
    localparam int AVG_FIELD_W    = 12;

    // derived widths
    localparam int SAMPLE_W = (SAMPLE_BITS < SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SCAN_W   = $clog2(CHANNELS + 1);
    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int WIN_DEPTH = CHANNELS * WINDOW;
    localparam int WIN_AW   = $clog2(WIN_DEPTH);
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);

    // stream packing
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // input request, tdata bits
    localparam int S_SAMPLE_LSB = 0;
    localparam int S_RCH_LSB    = S_SAMPLE_LSB + SAMPLE_FIELD_W;

    // result, tdata bits
    localparam int M_SCH_LSB  = 0;
    localparam int M_SAVG_LSB = M_SCH_LSB + CHAN_FIELD_W;
    localparam int M_RAVG_LSB = M_SAVG_LSB + AVG_FIELD_W;
    localparam int M_USED_W   = M_RAVG_LSB + AVG_FIELD_W;

endpackage

>>> src/mmas_ram.sv
// ============================================================================
// mmas_ram - generic single-port-write RAM with registered read
// One write and one read per cycle; read data updates only when rd_en is high.
// ============================================================================
module mmas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, returns old data on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/multichannel_moving_average_sampler.sv
// ============================================================================
// multichannel_moving_average_sampler - scanned boxcar averaging of channels
// Stores one converter sample per request into the scanned channel's window
// slot, keeps per-channel running sums and returns floored averages.
// ============================================================================
//
//  channel  | dir | handshake          | tuser         | tdata
//  ---------+-----+--------------------+---------------+------------------------------
//  s_axis   | in  | s_tvalid/s_tready  | period_start  | sample_value, read_channel
//  m_axis   | out | m_tvalid/m_tready  | sample_stored | stored_channel, stored/read avg
//
//  One request per cycle unless the result stalls; a taken request passes the read stage
//  (window/sum memory read at the accepting edge), then updates into the result register.
//  Throughput is set by the read-modify-write of the sum memory, forwarded so
//  that back-to-back requests to the same channel see the freshest sum.
//  Reset clears the scan position, slot cursor and the valid bits that make
//  never-written window entries and sums read as zero; no clearing pass.
//  A stalled result holds the update stage; one more request is still taken.
//
module multichannel_moving_average_sampler (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mmas_pkg::S_TDATA_W-1:0] s_tdata,  // sample_value[11:0], read_channel[14:12]
    input  logic                          s_tuser,   // period_start
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mmas_pkg::M_TDATA_W-1:0] m_tdata,  // stored_channel[2:0], stored_average[14:3],
                                                     // read_average[26:15]
    output logic                          m_tuser    // sample_stored
);

    import mmas_pkg::*;

    // ------------------------------------------------------------------
    // request fields
    logic                    period_start;
    logic [SAMPLE_W-1:0]     sample_in;
    logic [CHAN_FIELD_W-1:0] read_channel;

    assign period_start = s_tuser;
    assign sample_in    = s_tdata[S_SAMPLE_LSB +: SAMPLE_W];
    assign read_channel = s_tdata[S_RCH_LSB +: CHAN_FIELD_W];

    // ------------------------------------------------------------------
    // scan state
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // read stage
    logic                s1_valid_reg;
    logic                s1_store_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic [WIN_AW-1:0]   s1_addr_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [CH_W-1:0]     s1_rch_reg;
    logic                s1_rch_ok_reg;
    logic                s1_fwd_a_reg;
    logic                s1_fwd_b_reg;
    logic [SUM_W-1:0]    s1_fwd_sum_reg;

    // result register
    logic                   m_valid_reg;
    logic                   m_stored_reg;
    logic [CHAN_FIELD_W-1:0] m_sch_reg;
    logic [AVG_FIELD_W-1:0] m_savg_reg;
    logic [AVG_FIELD_W-1:0] m_ravg_reg;

    // valid bits for never-written entries
    logic [WIN_DEPTH-1:0] win_vld_reg;
    logic [CHANNELS-1:0]  sum_vld_reg;

    // memory read data
    logic [SAMPLE_W-1:0] win_rd;
    logic [SUM_W-1:0]    suma_rd;
    logic [SUM_W-1:0]    sumb_rd;

    // ------------------------------------------------------------------
    // handshake
    logic accept;
    logic b_adv;
    logic b_fire;
    logic wb_en;

    assign b_adv    = !m_valid_reg || m_tready;
    assign b_fire   = s1_valid_reg && b_adv;
    assign wb_en    = b_fire && s1_store_reg;
    assign s_tready = !s1_valid_reg || b_adv;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // scan position and window address for the incoming request
    logic [SCAN_W-1:0] scan_eff;
    logic [SLOT_W-1:0] slot_eff;
    logic              store_a;
    logic [CH_W-1:0]   ch_a;
    logic [WIN_AW-1:0] addr_a;
    logic              rch_ok_a;
    logic [CH_W-1:0]   rch_a;

    always_comb begin
        scan_eff = scan_reg;
        slot_eff = slot_reg;
        if (period_start) begin
            scan_eff = '0;
            if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                slot_eff = '0;
            end else begin
                slot_eff = slot_reg + 1'b1;
            end
        end
        store_a  = (scan_eff < SCAN_W'(CHANNELS));
        ch_a     = CH_W'(scan_eff);
        addr_a   = WIN_AW'(ch_a) * WIN_AW'(WINDOW) + WIN_AW'(slot_eff);
        rch_ok_a = ({1'b0, read_channel} < (CHAN_FIELD_W + 1)'(CHANNELS));
        rch_a    = CH_W'(read_channel);
        scan_next = store_a ? scan_eff + 1'b1 : scan_eff;
        slot_next = slot_eff;
    end

    // ------------------------------------------------------------------
    // update stage: old entry out, new sample in
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    sum_old;
    logic [SUM_W-1:0]    sum_new;
    logic [SUM_W-1:0]    rsum;
    logic [SUM_W-1:0]    savg_full;
    logic [SUM_W-1:0]    ravg_full;

    always_comb begin
        old_sample = win_vld_reg[s1_addr_reg] ? win_rd : '0;
        if (s1_fwd_a_reg) begin
            sum_old = s1_fwd_sum_reg;
        end else if (sum_vld_reg[s1_ch_reg]) begin
            sum_old = suma_rd;
        end else begin
            sum_old = '0;
        end
        sum_new = sum_old - SUM_W'(old_sample) + SUM_W'(s1_sample_reg);

        // read channel sees this request's own update
        if (!s1_rch_ok_reg) begin
            rsum = '0;
        end else if (s1_store_reg && (s1_rch_reg == s1_ch_reg)) begin
            rsum = sum_new;
        end else if (s1_fwd_b_reg) begin
            rsum = s1_fwd_sum_reg;
        end else if (sum_vld_reg[s1_rch_reg]) begin
            rsum = sumb_rd;
        end else begin
            rsum = '0;
        end

        savg_full = s1_store_reg ? sum_new / SUM_W'(WINDOW) : '0;
        ravg_full = rsum / SUM_W'(WINDOW);
    end

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg     <= '0;
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            win_vld_reg  <= '0;
            sum_vld_reg  <= '0;
        end else begin
            if (accept) begin
                scan_reg <= scan_next;
                slot_reg <= slot_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (b_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (b_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (wb_en) begin
                win_vld_reg[s1_addr_reg] <= 1'b1;
                sum_vld_reg[s1_ch_reg]   <= 1'b1;
            end
        end
    end

    // read stage payload, with forwarding of the sum written back this edge
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_store_reg   <= store_a;
            s1_ch_reg      <= ch_a;
            s1_addr_reg    <= addr_a;
            s1_sample_reg  <= sample_in;
            s1_rch_reg     <= rch_a;
            s1_rch_ok_reg  <= rch_ok_a;
            s1_fwd_a_reg   <= wb_en && (s1_ch_reg == ch_a);
            s1_fwd_b_reg   <= wb_en && (s1_ch_reg == rch_a);
            s1_fwd_sum_reg <= sum_new;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (b_fire) begin
            m_stored_reg <= s1_store_reg;
            m_sch_reg    <= s1_store_reg ? CHAN_FIELD_W'(s1_ch_reg) : '0;
            m_savg_reg   <= AVG_FIELD_W'(savg_full);
            m_ravg_reg   <= AVG_FIELD_W'(ravg_full);
        end
    end

    // ------------------------------------------------------------------
    // window store
    mmas_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WIN_DEPTH)
    ) u_win_ram (
        .aclk    (aclk),
        .wr_en   (wb_en),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_sample_reg),
        .rd_en   (accept),
        .rd_addr (addr_a),
        .rd_data (win_rd)
    );

    // running sums, copy read at the stored channel
    mmas_ram #(
        .WIDTH (SUM_W),
        .DEPTH (CHANNELS)
    ) u_suma_ram (
        .aclk    (aclk),
        .wr_en   (wb_en),
        .wr_addr (s1_ch_reg),
        .wr_data (sum_new),
        .rd_en   (accept),
        .rd_addr (ch_a),
        .rd_data (suma_rd)
    );

    // running sums, copy read at the read channel
    mmas_ram #(
        .WIDTH (SUM_W),
        .DEPTH (CHANNELS)
    ) u_sumb_ram (
        .aclk    (aclk),
        .wr_en   (wb_en),
        .wr_addr (s1_ch_reg),
        .wr_data (sum_new),
        .rd_en   (accept),
        .rd_addr (rch_a),
        .rd_data (sumb_rd)
    );

    // ------------------------------------------------------------------
    // result port
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_stored_reg;
    assign m_tdata  = {(M_TDATA_W - M_USED_W)'(0), m_ravg_reg, m_savg_reg, m_sch_reg};

endmodule

>>> src/mmas_checker.sv
// ============================================================================
// mmas_checker - port-level checks for the moving average sampler
// Watches the stream ports over time; attached to the top level by bind.
// ============================================================================
module mmas_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mmas_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    import mmas_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // an empty result register always lets a request in
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request blocked with empty result register");

    // a result that stored nothing reports no channel and no stored average
    a_unstored_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[M_RAVG_LSB-1:0] == '0)
        else $error("unstored result carries channel or average");

    // stored channel stays within the scanned range
    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            {1'b0, m_tdata[M_SCH_LSB +: CHAN_FIELD_W]} < (CHAN_FIELD_W + 1)'(CHANNELS))
        else $error("stored channel out of range");

endmodule

bind multichannel_moving_average_sampler mmas_checker u_mmas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> bench/mmas_average_checker.sv
// ============================================================================
// mmas_average_checker - result checker for the moving average sampler
// Watches both stream channels, keeps its own copy of the sample windows and
// running sums, predicts the result of every accepted request and compares
// each accepted result, field by field, with the oldest prediction.
// ============================================================================
module mmas_average_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [mmas_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                       s_tuser,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [mmas_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                       m_tuser,
    output int                         fail_count,
    output int                         pending_count
);
    import mmas_pkg::*;

    typedef struct packed {
        logic                      stored;
        logic [CHAN_FIELD_W-1:0]   channel;
        logic [AVG_FIELD_W-1:0]    stored_avg;
        logic [AVG_FIELD_W-1:0]    read_avg;
    } average_result_t;

    // mirrored sampler state
    logic [SAMPLE_W-1:0] window_mem [CHANNELS][WINDOW];
    logic [SUM_W-1:0]    channel_sum [CHANNELS];
    logic [SLOT_W-1:0]   slot_idx;
    logic [SCAN_W-1:0]   scan_idx;

    average_result_t expected_averages [$];

    // floored window average, zero for channels past the last one
    function automatic logic [AVG_FIELD_W-1:0] window_average(input int ch);
        if (ch >= CHANNELS)
            return '0;
        return AVG_FIELD_W'(int'(channel_sum[ch]) / WINDOW);
    endfunction

    // one tick: optional period restart, then store into the scanned channel if the scan is not done
    function automatic average_result_t sample_and_average(
        input logic                    period_start,
        input logic [SAMPLE_FIELD_W-1:0] sample_in,
        input logic [CHAN_FIELD_W-1:0] read_ch
    );
        average_result_t res;
        logic [SAMPLE_W-1:0] sample;
        int ch;
        res    = '0;
        sample = sample_in[SAMPLE_W-1:0];
        if (period_start) begin
            scan_idx = '0;
            if (int'(slot_idx) + 1 >= WINDOW)
                slot_idx = '0;
            else
                slot_idx = slot_idx + 1'b1;
        end
        if (int'(scan_idx) < CHANNELS) begin
            ch = int'(scan_idx);
            channel_sum[ch] = channel_sum[ch] - SUM_W'(window_mem[ch][slot_idx])
                              + SUM_W'(sample);
            window_mem[ch][slot_idx] = sample;
            res.stored     = 1'b1;
            res.channel    = CHAN_FIELD_W'(ch);
            res.stored_avg = window_average(ch);
            scan_idx       = scan_idx + 1'b1;
        end
        res.read_avg = window_average(int'(read_ch));
        return res;
    endfunction

    task automatic report_mismatch(input string what, input average_result_t want,
                                   input average_result_t got);
        fail_count++;
        if (fail_count <= 10) begin
            $write("%0t: %s: expected stored=%0d ch=%0d savg=%0d ravg=%0d, ",
                   $realtime, what, want.stored, want.channel, want.stored_avg,
                   want.read_avg);
            $display("got stored=%0d ch=%0d savg=%0d ravg=%0d",
                     got.stored, got.channel, got.stored_avg, got.read_avg);
        end
    endtask

    // sample both channels at the rising edge; results before new requests
    always @(posedge aclk) begin
        average_result_t got;
        average_result_t want;
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                channel_sum[c] = '0;
                for (int w = 0; w < WINDOW; w++)
                    window_mem[c][w] = '0;
            end
            slot_idx   = '0;
            scan_idx   = '0;
            fail_count = 0;
            expected_averages.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.stored     = m_tuser;
                got.channel    = m_tdata[M_SCH_LSB +: CHAN_FIELD_W];
                got.stored_avg = m_tdata[M_SAVG_LSB +: AVG_FIELD_W];
                got.read_avg   = m_tdata[M_RAVG_LSB +: AVG_FIELD_W];
                if (expected_averages.size() == 0) begin
                    report_mismatch("result with no request pending", '0, got);
                end else begin
                    want = expected_averages.pop_front();
                    if (got !== want)
                        report_mismatch("result mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready)
                expected_averages.push_back(sample_and_average(
                    s_tuser,
                    s_tdata[S_SAMPLE_LSB +: SAMPLE_FIELD_W],
                    s_tdata[S_RCH_LSB +: CHAN_FIELD_W]));
        end
        pending_count = expected_averages.size();
    end

endmodule

>>> bench/tb.sv
// ============================================================================
// tb - testbench top for the moving average sampler
// Drives directed and random sampling periods with random idle gaps on both
// channels and one long result back-pressure stretch; the checker predicts
// and compares every result and this module gives the verdict.
// ============================================================================
module tb;
    import mmas_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int LONG_HOLD    = 300;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // sample_value[11:0], read_channel[14:12]
    logic                   s_tuser;   // period_start
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // stored_channel[2:0], stored_average[14:3],
                                       // read_average[26:15]
    logic                   m_tuser;   // sample_stored

    int  fail_count;
    int  pending_count;
    int  cycle_count = 0;
    bit  sender_no_idle;

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    multichannel_moving_average_sampler u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mmas_average_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // sender idle length: mostly none, some short, a few long
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sample value for one of the level modes of a phase
    function automatic logic [SAMPLE_FIELD_W-1:0] pick_sample(input int level_mode);
        case (level_mode)
            1: begin
                return '1;
            end
            2: begin
                return '0;
            end
            3: begin
                return SAMPLE_FIELD_W'($urandom_range(4000, 4095));
            end
            default: begin
                return SAMPLE_FIELD_W'($urandom);
            end
        endcase
    endfunction

    // offer one request and wait until it is taken
    task automatic send_request(input logic period_start,
                                input logic [SAMPLE_FIELD_W-1:0] sample,
                                input logic [CHAN_FIELD_W-1:0] read_ch);
        logic [S_TDATA_W-1:0] word;
        int gap;
        word = '0;
        word[S_SAMPLE_LSB +: SAMPLE_FIELD_W] = sample;
        word[S_RCH_LSB +: CHAN_FIELD_W]      = read_ch;
        gap  = sender_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= period_start;
        do @(posedge aclk); while (!s_tready);
    endtask

    // result side: random ready pattern plus one long hold-off
    initial begin
        int  r;
        int  len;
        bit  held;
        bit  ready_now;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            r = $urandom_range(0, 99);
            if (!held && cycle_count >= 600) begin
                held      = 1'b1;
                ready_now = 1'b0;
                len       = LONG_HOLD;
            end else if (r < 50) begin
                ready_now = 1'b1;
                len       = $urandom_range(1, 20);
            end else if (r < 80) begin
                ready_now = 1'b0;
                len       = $urandom_range(1, 3);
            end else if (r < 93) begin
                ready_now = 1'b1;
                len       = $urandom_range(40, 80);
            end else begin
                ready_now = 1'b0;
                len       = $urandom_range(8, 30);
            end
            @(negedge aclk);
            m_tready <= ready_now;
            repeat (len - 1) @(negedge aclk);
        end
    end

    // stimulus and verdict
    initial begin
        int items_sent;
        int phase_left;
        int level_mode;
        int n_items;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        aresetn        = 1'b0;
        sender_no_idle = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // first period runs from reset at slot 0 without a period start
        send_request(1'b0, 12'hFFF, 3'd0);
        send_request(1'b0, 12'h000, 3'd1);
        send_request(1'b0, 12'hFFF, 3'd2);
        send_request(1'b0, 12'hAAA, 3'd3);
        send_request(1'b0, 12'h555, 3'd4);
        // scan finished, and read channels past the last one
        send_request(1'b0, 12'h4D2, 3'd5);
        send_request(1'b0, 12'hFFF, 3'd6);
        send_request(1'b0, 12'h000, 3'd7);
        // full period at the top of the range
        send_request(1'b1, 12'hFFF, 3'd0);
        send_request(1'b0, 12'hFFF, 3'd1);
        send_request(1'b0, 12'hFFF, 3'd2);
        send_request(1'b0, 12'hFFF, 3'd3);
        send_request(1'b0, 12'hFFF, 3'd4);
        send_request(1'b0, 12'hFFF, 3'd0);
        // period restarts mid-scan and back to back
        send_request(1'b1, 12'h000, 3'd2);
        send_request(1'b0, 12'hFFF, 3'd3);
        send_request(1'b1, 12'hFFF, 3'd4);
        send_request(1'b1, 12'h800, 3'd0);
        send_request(1'b0, 12'h001, 3'd1);

        // random periods grouped in phases of one level mode
        items_sent = 0;
        phase_left = 0;
        level_mode = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                level_mode     = $urandom_range(0, 3);
                phase_left     = $urandom_range(10, 24);
                sender_no_idle = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            if ($urandom_range(0, 99) < 15)
                n_items = $urandom_range(1, CHANNELS - 1);
            else if ($urandom_range(0, 99) < 30)
                n_items = CHANNELS + $urandom_range(1, 3);
            else
                n_items = CHANNELS;
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(0, 99) < 3)
                    send_request(1'($urandom), SAMPLE_FIELD_W'($urandom),
                                 CHAN_FIELD_W'($urandom));
                else
                    send_request(k == 0, pick_sample(level_mode),
                                 CHAN_FIELD_W'($urandom_range(0, 7)));
                items_sent++;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain and let the pipeline settle
        while (pending_count != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
src/mmas_pkg.sv
src/mmas_ram.sv
src/multichannel_moving_average_sampler.sv
src/mmas_checker.sv
bench/mmas_average_checker.sv
bench/tb.sv
